// ===== rtl/core/rrqi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqi_pkg: shared definitions for the round-robin queue interleave
// Default sizes, command codes and pass-order codes used by the block.
// ----------------------------------------------------------------------------
package rrqi_pkg;

   localparam int NUM_LISTS_DEF  = 8;
   localparam int LIST_DEPTH_DEF = 256;

   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 3;
   localparam int OP_W     = 2;
   localparam int MODE_W   = 2;
   localparam int SOURCE_W = 3;

   // Command codes carried in the request tuser field.
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OP_W-1:0] OP_TAKE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   // Pass-order codes held in the mode register; the unused code acts as ascending.
   localparam logic [MODE_W-1:0] MODE_ASC    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DESC   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ZIGZAG = 2'd2;

endpackage

// ===== rtl/core/round_robin_queue_interleave.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_queue_interleave: interleaved take from NUM_LISTS FIFO queues
// Bounded FIFO queues in one shared item memory, drained in round-robin passes.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the req_ stream: tuser carries the command (push,
// take, clear), tdata the queue number and the value of a push. Every command
// produces exactly one item on the rsp_ stream. A push answers with
// push_rejected set when the queue is full or the queue number is out of
// range. A take answers with the next value in interleaved order, its source
// queue and item_valid set, or with all fields zero when every queue is empty.
// The csr_ port writes the pass-order mode and must only be used while idle.
//
// Timing. A command is accepted in the idle state only, so a new command is
// not taken before the last one is finished. Push, clear, unused codes and a
// take on empty queues pass through the metadata step; a take that finds a
// value also passes through the data step, as the per-queue head/count memory
// read is followed by the item memory read. The result is loaded into the
// output register at the end of the last step.
//
// Reset empties all queues through per-queue occupancy flags, so no clearing
// pass over the memories is needed. When the receiver stalls, the finished
// result holds in the output register and the block waits in its last step.
// ----------------------------------------------------------------------------
module round_robin_queue_interleave
   import rrqi_pkg::*;
#(
   parameter int NUM_LISTS  = NUM_LISTS_DEF,
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [2:0] list_index, [34:3] value, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // Response stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] item_value, [34:32] source_queue
   output logic [1:0]  rsp_tuser,   // [0] item_valid, [1] push_rejected
   // Configuration.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   localparam int QW = $clog2(NUM_LISTS);
   localparam int HW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int MW = HW + CW;
   localparam int AW = $clog2(NUM_LISTS * LIST_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_META = 3'b010,
      ST_DATA = 3'b100
   } state_type;

   function automatic logic descends(logic [MODE_W-1:0] m, logic par);
      return (m == MODE_DESC) || ((m == MODE_ZIGZAG) && par);
   endfunction

   function automatic logic [QW-1:0] first_of_pass(logic [MODE_W-1:0] m, logic par);
      return descends(m, par) ? QW'(NUM_LISTS - 1) : '0;
   endfunction

   // Control registers.
   state_type              state_ff, state_in;
   logic [MODE_W-1:0]      mode_ff;
   logic [NUM_LISTS-1:0]   flags_ff;   // one bit per queue: queue holds items
   logic [QW-1:0]          scan_ff;
   logic                   parity_ff;
   logic                   rsp_valid_ff;

   // Command registers captured at acceptance.
   logic [OP_W-1:0]        op_ff;
   logic [QW-1:0]          q_ff;
   logic                   idx_ok_ff;
   logic [VALUE_W-1:0]     val_ff;
   logic                   hit_ff;

   // Output register.
   logic [VALUE_W-1:0]     out_value_ff;
   logic [SOURCE_W-1:0]    out_source_ff;
   logic                   out_item_valid_ff;
   logic                   out_rejected_ff;

   // Request fields.
   logic [OP_W-1:0]        req_op;
   logic [INDEX_W-1:0]     req_idx;
   logic [VALUE_W-1:0]     req_val;
   logic                   req_fire;
   logic                   out_free;

   assign req_op   = req_tuser[OP_W-1:0];
   assign req_idx  = req_tdata[INDEX_W-1:0];
   assign req_val  = req_tdata[INDEX_W+VALUE_W-1:INDEX_W];
   assign req_fire = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);

   // ------------------------------------------------------------------------
   // Queue selection for a take. The rest of the current pass is searched
   // first; when it holds only empty queues a new pass starts and the whole
   // flag vector is searched in the new direction. The scan state after the
   // take is worked out here too and stored at acceptance.
   // ------------------------------------------------------------------------
   logic            any_full;
   logic            desc_a, desc_b;
   logic            hit_a;
   logic [QW-1:0]   q_a, q_b, q_sel;
   logic            par_b, par_c;
   logic [QW-1:0]   scan_c;

   always_comb begin
      any_full = |flags_ff;
      desc_a   = descends(mode_ff, parity_ff);
      hit_a    = 1'b0;
      q_a      = '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
         if (desc_a) begin
            if (flags_ff[i] && (QW'(i) <= scan_ff)) begin
               hit_a = 1'b1;
               q_a   = QW'(i);
            end
         end else begin
            if (flags_ff[NUM_LISTS-1-i] && (QW'(NUM_LISTS - 1 - i) >= scan_ff)) begin
               hit_a = 1'b1;
               q_a   = QW'(NUM_LISTS - 1 - i);
            end
         end
      end

      par_b  = hit_a ? parity_ff : ~parity_ff;
      desc_b = descends(mode_ff, par_b);
      q_b    = '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
         if (desc_b) begin
            if (flags_ff[i]) begin
               q_b = QW'(i);
            end
         end else begin
            if (flags_ff[NUM_LISTS-1-i]) begin
               q_b = QW'(NUM_LISTS - 1 - i);
            end
         end
      end
      q_sel = hit_a ? q_a : q_b;

      // Step past the chosen queue; the end of a pass opens the next one.
      par_c  = par_b;
      scan_c = '0;
      if (desc_b) begin
         if (q_sel == '0) begin
            par_c  = ~par_b;
            scan_c = first_of_pass(mode_ff, ~par_b);
         end else begin
            scan_c = q_sel - QW'(1);
         end
      end else begin
         if (q_sel == QW'(NUM_LISTS - 1)) begin
            par_c  = ~par_b;
            scan_c = first_of_pass(mode_ff, ~par_b);
         end else begin
            scan_c = q_sel + QW'(1);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Per-queue head and count memory. An entry whose occupancy flag is clear
   // reads as head zero and count zero.
   // ------------------------------------------------------------------------
   logic            meta_rd_en;
   logic [QW-1:0]   meta_rd_addr;
   logic [MW-1:0]   meta_rd_data;
   logic            meta_wr_en;
   logic [MW-1:0]   meta_wr_data;

   assign meta_rd_en   = req_fire;
   assign meta_rd_addr = (req_op == OP_PUSH) ? QW'(req_idx) : q_sel;

   rrqi_ram #(
      .WIDTH (MW),
      .DEPTH (NUM_LISTS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_wr_en),
      .wr_addr (q_ff),
      .wr_data (meta_wr_data),
      .rd_en   (meta_rd_en),
      .rd_addr (meta_rd_addr),
      .rd_data (meta_rd_data)
   );

   // Read-modify-write of the selected queue in the metadata step.
   logic            cur_valid;
   logic [HW-1:0]   cur_head;
   logic [CW-1:0]   cur_count;
   logic [CW:0]     slot_sum;
   logic [HW-1:0]   slot;
   logic [HW-1:0]   head_next;
   logic [CW-1:0]   count_dec;
   logic            is_push, is_take_hit, is_clear;
   logic            push_reject;
   logic            push_write;
   logic [AW-1:0]   store_addr;

   always_comb begin
      cur_valid = flags_ff[q_ff];
      cur_head  = cur_valid ? meta_rd_data[MW-1:CW] : '0;
      cur_count = cur_valid ? meta_rd_data[CW-1:0]  : '0;

      // The ring slot of the tail stays below twice the depth.
      slot_sum = (CW+1)'(cur_head) + (CW+1)'(cur_count);
      if (slot_sum >= (CW+1)'(LIST_DEPTH)) begin
         slot = HW'(slot_sum - (CW+1)'(LIST_DEPTH));
      end else begin
         slot = HW'(slot_sum);
      end

      head_next = (cur_head == HW'(LIST_DEPTH - 1)) ? '0 : cur_head + HW'(1);
      count_dec = cur_count - CW'(1);

      is_push     = (state_ff == ST_META) && (op_ff == OP_PUSH);
      is_take_hit = (state_ff == ST_META) && hit_ff;
      is_clear    = (state_ff == ST_META) && (op_ff == OP_CLEAR);
      push_reject = !idx_ok_ff || (cur_count >= CW'(LIST_DEPTH));
      push_write  = is_push && !push_reject && out_free;

      store_addr = AW'(q_ff) * AW'(LIST_DEPTH) + AW'(is_push ? slot : cur_head);

      meta_wr_en   = push_write || is_take_hit;
      meta_wr_data = is_push ? {cur_head, cur_count + CW'(1)} : {head_next, count_dec};
   end

   // ------------------------------------------------------------------------
   // Shared item memory: queue q owns entries q*LIST_DEPTH and up as a ring.
   // ------------------------------------------------------------------------
   logic [VALUE_W-1:0] store_rd_data;

   rrqi_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (NUM_LISTS * LIST_DEPTH)
   ) u_item_ram (
      .clock   (clock),
      .wr_en   (push_write),
      .wr_addr (store_addr),
      .wr_data (val_ff),
      .rd_en   (is_take_hit),
      .rd_addr (store_addr),
      .rd_data (store_rd_data)
   );

   // ------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------
   logic out_load;

   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_META;
            end
         end
         ST_META: begin
            if (hit_ff) begin
               state_in = ST_DATA;
            end else if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_ASC;
         flags_ff     <= '0;
         scan_ff      <= '0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end

         if (req_fire) begin
            hit_ff <= (req_op == OP_TAKE) && any_full;
            if ((req_op == OP_TAKE) && any_full) begin
               scan_ff   <= scan_c;
               parity_ff <= par_c;
            end
         end else if (is_take_hit) begin
            hit_ff <= 1'b0;
         end

         if (push_write) begin
            flags_ff[q_ff] <= 1'b1;
         end
         if (is_take_hit && (count_dec == '0)) begin
            flags_ff[q_ff] <= 1'b0;
         end
         if (is_clear && out_free) begin
            flags_ff  <= '0;
            parity_ff <= 1'b0;
            scan_ff   <= first_of_pass(mode_ff, 1'b0);
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Command capture and output payload; these need no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= req_op;
         q_ff      <= (req_op == OP_PUSH) ? QW'(req_idx) : q_sel;
         idx_ok_ff <= (32'(req_idx) < NUM_LISTS);
         val_ff    <= req_val;
      end
      if (out_load) begin
         if (state_ff == ST_DATA) begin
            out_value_ff      <= store_rd_data;
            out_source_ff     <= SOURCE_W'(q_ff);
            out_item_valid_ff <= 1'b1;
            out_rejected_ff   <= 1'b0;
         end else begin
            out_value_ff      <= '0;
            out_source_ff     <= '0;
            out_item_valid_ff <= 1'b0;
            out_rejected_ff   <= is_push && push_reject;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, out_source_ff, out_value_ff};
   assign rsp_tuser  = {out_rejected_ff, out_item_valid_ff};

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   // A take that goes to the memories was aimed at a queue that holds items.
   a_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      is_take_hit |-> flags_ff[q_ff])
      else $error("take selected an empty queue");

   // A completed clear leaves every queue empty.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (is_clear && out_free) |=> (flags_ff == '0))
      else $error("queues not empty after clear");

   // An accepted push marks its queue as holding items.
   a_push_marks: assert property (@(posedge clock) disable iff (reset)
      push_write |=> flags_ff[q_ff])
      else $error("pushed queue not marked");

   // The scan position always names an existing queue.
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (32'(scan_ff) < NUM_LISTS))
      else $error("scan position out of range");

endmodule

// ===== rtl/core/rrqi_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrqi_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module rrqi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== tb/round_robin_queue_interleave_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_queue_interleave_tb: self-checking bench for the queue interleave
// Drives push, take, clear and unused commands through the request stream,
// predicts every response with a cycle-free model of the queues and the pass
// scan, and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module round_robin_queue_interleave_tb;
   import rrqi_pkg::*;

   localparam int LISTS = NUM_LISTS_DEF;
   localparam int DEPTH = LIST_DEPTH_DEF;

   // Codes the package leaves unnamed: both must behave as documented.
   localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int SETTLE_CYCLES    = 4;
   localparam int DRAIN_CYCLES     = 10;
   localparam int RANDOM_PER_PHASE = 70;
   localparam int PHASES           = 4;

   // Pass order written at the start of each phase, four phases per idle pattern.
   localparam logic [MODE_W-1:0] PHASE_MODES [3*PHASES] = '{
      MODE_DESC, MODE_ZIGZAG, MODE_ASC, MODE_UNUSED,
      MODE_ZIGZAG, MODE_DESC, MODE_UNUSED, MODE_ASC,
      MODE_ASC, MODE_ZIGZAG, MODE_DESC, MODE_ZIGZAG
   };

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [INDEX_W-1:0] list_index;
      logic [VALUE_W-1:0] value;
   } command_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  item_value;
      logic [SOURCE_W-1:0] source_queue;
      logic                item_valid;
      logic                push_rejected;
   } response_type;

   // Clock, reset and every block input start at known values.
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata   = '0;   // [2:0] list_index, [34:3] value, rest zero
   logic [1:0]  req_tuser   = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;          // [31:0] item_value, [34:32] source_queue
   logic [1:0]  rsp_tuser;          // [0] item_valid, [1] push_rejected
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_wr_data = '0;

   round_robin_queue_interleave #(
      .NUM_LISTS  (LISTS),
      .LIST_DEPTH (DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shadow of the queues and the pass scan. It is updated once per accepted
   // item, in acceptance order, so it needs no notion of the block's timing.
   // ------------------------------------------------------------------------
   logic [VALUE_W-1:0] shadow_store [LISTS][DEPTH];
   int                 shadow_head  [LISTS];
   int                 shadow_count [LISTS];
   int                 shadow_scan;
   logic               shadow_parity;
   logic [MODE_W-1:0]  shadow_mode;

   // Descending passes come from the descending mode, or from the odd passes
   // of zigzag. The unused mode code falls through to ascending.
   function automatic logic pass_descends();
      return (shadow_mode == MODE_DESC) || (shadow_mode == MODE_ZIGZAG && shadow_parity);
   endfunction

   function automatic void start_next_pass();
      shadow_parity = ~shadow_parity;
      shadow_scan   = pass_descends() ? LISTS - 1 : 0;
   endfunction

   // First non-empty queue from the scan position to the end of the pass,
   // or -1 when the rest of the pass holds only empty queues.
   function automatic int find_in_pass();
      if (pass_descends()) begin
         for (int q = shadow_scan; q >= 0; q--)
            if (shadow_count[q] != 0) return q;
      end else begin
         for (int q = shadow_scan; q < LISTS; q++)
            if (shadow_count[q] != 0) return q;
      end
      return -1;
   endfunction

   // Applies one command to the shadow and returns the response it causes.
   function automatic response_type next_response(command_type cmd);
      response_type rsp;
      int           q;
      int           slot;
      logic         any_held;
      rsp      = '0;
      any_held = 1'b0;
      case (cmd.operation)
         OP_PUSH: begin
            q = cmd.list_index;
            if (q >= LISTS || shadow_count[q] >= DEPTH) begin
               rsp.push_rejected = 1'b1;
            end else begin
               slot = (shadow_head[q] + shadow_count[q]) % DEPTH;
               shadow_store[q][slot] = cmd.value;
               shadow_count[q]++;
            end
         end
         OP_TAKE: begin
            for (int i = 0; i < LISTS; i++)
               if (shadow_count[i] != 0) any_held = 1'b1;
            // With every queue empty the scan state stays where it is.
            if (any_held) begin
               q = find_in_pass();
               if (q < 0) begin
                  start_next_pass();
                  q = find_in_pass();
               end
               if (q >= 0) begin
                  rsp.item_value   = shadow_store[q][shadow_head[q]];
                  rsp.item_valid   = 1'b1;
                  rsp.source_queue = q[SOURCE_W-1:0];
                  shadow_head[q]   = (shadow_head[q] + 1) % DEPTH;
                  shadow_count[q]--;
                  if (pass_descends()) begin
                     if (q == 0) start_next_pass();
                     else shadow_scan = q - 1;
                  end else begin
                     if (q + 1 >= LISTS) start_next_pass();
                     else shadow_scan = q + 1;
                  end
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < LISTS; i++) begin
               shadow_head[i]  = 0;
               shadow_count[i] = 0;
            end
            shadow_parity = 1'b0;
            shadow_scan   = pass_descends() ? LISTS - 1 : 0;
         end
         default: begin
            // The unused code leaves everything alone and answers all zero.
         end
      endcase
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // Bookkeeping shared by the driver, the monitor and the stimulus process.
   // ------------------------------------------------------------------------
   command_type  command_queue [$];
   response_type expected_responses [$];
   command_type  next_cmd;
   logic      req_taken = 1'b0;
   int        queued_total   = 0;
   int        accepted_count = 0;
   int        error_count    = 0;
   int        cycle_count    = 0;
   int        send_idle_pct  = 0;
   int        recv_stall_pct = 0;

   // Tallies for the closing summary.
   int stored_pushes   = 0;
   int rejected_pushes = 0;
   int delivered_takes = 0;
   int empty_takes     = 0;
   int clears_seen     = 0;
   int unused_seen     = 0;

   initial begin
      for (int i = 0; i < LISTS; i++) begin
         shadow_head[i]  = 0;
         shadow_count[i] = 0;
      end
      shadow_scan   = 0;
      shadow_parity = 1'b0;
      shadow_mode   = MODE_ASC;
   end

   // Driver: at the falling edge it offers the next pending item once the
   // previous one was taken, or idles at the chosen rate. The receiver side
   // of the response stream stalls at its own rate.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_taken) begin
            if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd    = command_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {5'd0, next_cmd.value, next_cmd.list_index};
               req_tuser  <= next_cmd.operation;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: at the rising edge it records configuration writes and accepted
   // items in the shadow, and checks each accepted response against the oldest
   // prediction.
   always @(posedge clock) begin
      response_type predicted;
      response_type observed;
      command_type  seen_cmd;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (csr_wr_en) shadow_mode = csr_wr_data;

         if (req_tvalid && req_tready) begin
            seen_cmd.operation  = req_tuser;
            seen_cmd.list_index = req_tdata[2:0];
            seen_cmd.value      = req_tdata[34:3];
            predicted = next_response(seen_cmd);
            expected_responses.push_back(predicted);
            accepted_count++;
            case (seen_cmd.operation)
               OP_PUSH:  if (predicted.push_rejected) rejected_pushes++;
                         else stored_pushes++;
               OP_TAKE:  if (predicted.item_valid) delivered_takes++;
                         else empty_takes++;
               OP_CLEAR: clears_seen++;
               default:  unused_seen++;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            observed.item_value    = rsp_tdata[31:0];
            observed.source_queue  = rsp_tdata[34:32];
            observed.item_valid    = rsp_tuser[0];
            observed.push_rejected = rsp_tuser[1];
            if (expected_responses.size() == 0) begin
               $display("%0t: response with none expected, expected nothing, actual %h",
                        $time, observed);
               error_count++;
            end else begin
               predicted = expected_responses.pop_front();
               if (observed.item_value !== predicted.item_value) begin
                  $display("%0t: item_value mismatch, expected %h, actual %h",
                           $time, predicted.item_value, observed.item_value);
                  error_count++;
               end
               if (observed.source_queue !== predicted.source_queue) begin
                  $display("%0t: source_queue mismatch, expected %0d, actual %0d",
                           $time, predicted.source_queue, observed.source_queue);
                  error_count++;
               end
               if (observed.item_valid !== predicted.item_valid) begin
                  $display("%0t: item_valid mismatch, expected %b, actual %b",
                           $time, predicted.item_valid, observed.item_valid);
                  error_count++;
               end
               if (observed.push_rejected !== predicted.push_rejected) begin
                  $display("%0t: push_rejected mismatch, expected %b, actual %b",
                           $time, predicted.push_rejected, observed.push_rejected);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   task automatic add_command(logic [OP_W-1:0] op, int list, logic [VALUE_W-1:0] value);
      command_type cmd;
      cmd.operation  = op;
      cmd.list_index = list[INDEX_W-1:0];
      cmd.value      = value;
      command_queue.push_back(cmd);
      queued_total++;
   endtask

   // Returns at a falling edge once every queued item was accepted and every
   // predicted response has arrived, after a further settling wait.
   task automatic wait_until_idle();
      while (accepted_count != queued_total || expected_responses.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(logic [MODE_W-1:0] mode_code);
      @(negedge clock);
      csr_wr_data <= mode_code;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(19))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Random commands in bursts that lean toward pushes or toward takes, so the
   // queues both fill up and run dry. Most pushes go to a random subset of the
   // queues, which leaves gaps for the scan to skip.
   task automatic add_random_commands(int count);
      logic [LISTS-1:0]  active_lists;
      logic [OP_W-1:0]   op;
      int                produced;
      int                burst_len;
      int                push_share;
      int                pick;
      int                list;
      active_lists = LISTS'($urandom_range(1, (1 << LISTS) - 1));
      produced     = 0;
      while (produced < count) begin
         burst_len  = $urandom_range(1, 10);
         push_share = ($urandom_range(99) < 55) ? 78 : 25;
         for (int n = 0; n < burst_len; n++) begin
            pick = $urandom_range(99);
            if (pick < 2)                    op = OP_CLEAR;
            else if (pick < 4)               op = OP_UNUSED;
            else if (pick < 4 + push_share)  op = OP_PUSH;
            else                             op = OP_TAKE;
            list = $urandom_range(LISTS - 1);
            if (op == OP_PUSH && $urandom_range(3) != 0) begin
               while (!active_lists[list]) list = $urandom_range(LISTS - 1);
            end
            add_command(op, list, random_value());
            if (op != OP_UNUSED) produced++;
         end
      end
   endtask

   // Fills one queue past its depth so the last pushes bounce, then issues twelve
   // takes, which may free entries in it, and pushes eight more values to it.
   task automatic add_fill_commands();
      int target;
      target = $urandom_range(LISTS - 1);
      for (int n = 0; n < DEPTH + 4; n++) add_command(OP_PUSH, target, random_value());
      for (int n = 0; n < 12; n++) add_command(OP_TAKE, 0, random_value());
      for (int n = 0; n < 8; n++) add_command(OP_PUSH, target, random_value());
   endtask

   // ------------------------------------------------------------------------
   // Run sequence.
   // ------------------------------------------------------------------------
   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset mode (ascending): empty takes, the
      // unused code, clear on empty queues, pushes to every queue with the value
      // extremes among them, takes that wrap the pass and run dry, and a take just after a clear.
      send_idle_pct  = 13;
      recv_stall_pct = 67;
      add_command(OP_TAKE,   0, 32'h0000_0000);
      add_command(OP_UNUSED, 0, 32'h0000_0000);
      add_command(OP_CLEAR,  0, 32'h0000_0000);
      add_command(OP_PUSH,   0, 32'h7FFF_FFFF);
      add_command(OP_PUSH,   7, 32'h8000_0000);
      add_command(OP_PUSH,   3, 32'h0000_0000);
      add_command(OP_PUSH,   3, 32'hFFFF_FFFF);
      add_command(OP_PUSH,   5, 32'h5555_5555);
      add_command(OP_PUSH,   1, 32'hAAAA_AAAA);
      add_command(OP_PUSH,   2, 32'h0000_0001);
      add_command(OP_PUSH,   4, 32'h8000_0001);
      add_command(OP_PUSH,   6, 32'h7FFF_FFFE);
      for (int n = 0; n < 10; n++) add_command(OP_TAKE, 0, 32'h0000_0000);
      add_command(OP_PUSH,   7, 32'h1234_5678);
      add_command(OP_PUSH,   0, 32'hFEDC_BA98);
      add_command(OP_CLEAR,  7, 32'hFFFF_FFFF);
      add_command(OP_TAKE,   7, 32'hFFFF_FFFF);
      add_command(OP_UNUSED, 7, 32'hFFFF_FFFF);

      // Three idle patterns: a slow receiver, a slow sender, then none at all.
      // Each one runs four phases with a new pass order; queues are not
      // cleared between phases, so the order also changes in mid pass.
      for (int pattern = 0; pattern < 3; pattern++) begin
         for (int phase = 0; phase < PHASES; phase++) begin
            wait_until_idle();
            write_mode(PHASE_MODES[pattern*PHASES + phase]);
            @(posedge clock);
            case (pattern)
               0:       begin send_idle_pct = 13; recv_stall_pct = 67; end
               1:       begin send_idle_pct = 67; recv_stall_pct = 13; end
               default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            if (pattern == 2 && phase == 0) add_fill_commands();
            if (pattern == 0 && phase == 1) begin
               // The sender holds back until every response is in.
               add_random_commands(RANDOM_PER_PHASE / 2);
               wait_until_idle();
               @(posedge clock);
               add_random_commands(RANDOM_PER_PHASE / 2);
            end else begin
               add_random_commands(RANDOM_PER_PHASE);
            end
         end
      end

      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d commands: %0d pushes stored, %0d refused as full, %0d takes",
               accepted_count, stored_pushes, rejected_pushes, delivered_takes + empty_takes);
      $display("  (%0d on empty queues), %0d clears, %0d unused codes, all four mode codes.",
               empty_takes, clears_seen, unused_seen);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
